### src/modbus_rtu_request_framer_defines.svh
// Assertion macros for the Modbus RTU request framer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mrf_pkg.sv
// Shared types, codes and tables for the Modbus RTU request framer.
// No dependencies; imported by every module of the block except mrf_crc_step.
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

   localparam int IDX_W = 3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [3:0] REQ_READ_COILS     = 4'd0;
   localparam logic [3:0] REQ_READ_DISCRETE  = 4'd1;
   localparam logic [3:0] REQ_READ_HOLDING   = 4'd2;
   localparam logic [3:0] REQ_READ_INPUT     = 4'd3;
   localparam logic [3:0] REQ_WRITE_COIL     = 4'd4;
   localparam logic [3:0] REQ_WRITE_REG      = 4'd5;
   localparam logic [3:0] REQ_WRITE_COILS    = 4'd6;
   localparam logic [3:0] REQ_WRITE_REGS     = 4'd7;
   localparam logic [3:0] REQ_PAYLOAD        = 4'd8;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [7:0]  device_address;
      logic [15:0] start_address;
      logic [15:0] qty_or_value;
      logic [15:0] data_word;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_last;
      logic       error;
   } rsp_word_type;

   typedef struct packed {
      logic       awaiting;
      logic       is_registers;
      logic [7:0] remaining;
   } frame_state_type;

   // One output byte and what it does to the CRC and item sequencing.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic       err;
      logic       feed_crc;
      logic       restart_crc;
      logic       clear_crc;
      logic       done;
   } emit_type;

   function automatic logic [7:0] fn_code(input logic [2:0] t);
      logic [7:0] code;
      unique case (t)
         3'd0: code = 8'h01;
         3'd1: code = 8'h02;
         3'd2: code = 8'h03;
         3'd3: code = 8'h04;
         3'd4: code = 8'h05;
         3'd5: code = 8'h06;
         3'd6: code = 8'h0F;
         3'd7: code = 8'h10;
      endcase
      return code;
   endfunction

   function automatic logic [15:0] qty_limit(input logic [2:0] t);
      logic [15:0] lim;
      unique case (t)
         3'd0, 3'd1: lim = 16'd2000;
         3'd2, 3'd3: lim = 16'd125;
         3'd4, 3'd5: lim = 16'd0;
         3'd6:       lim = 16'd1968;
         3'd7:       lim = 16'd123;
      endcase
      return lim;
   endfunction

endpackage

`default_nettype wire

### src/modbus_rtu_request_framer.sv
// Modbus RTU request framer top level: input register, byte sequencer, CRC, output register.
// The first byte of a word is loaded into the output register once the word is held in the input register.
// Throughput: one byte per cycle while the sink does not stall; a full header is 8 bytes, a multi-write header 7,
// a payload word 1 to 4, a rejected word 1; the byte index counter sets these figures.
// Reset: synchronous, clears the frame state and sets the CRC to all ones.
// Depends on mrf_pkg, mrf_crc_step, mrf_byte_gen, mrf_out_reg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_request_framer_defines.svh"

module modbus_rtu_request_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mrf_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mrf_pkg::rsp_word_type rsp_data
);
   import mrf_pkg::*;

   logic             in_valid_ff, in_valid_in;
   req_word_type     in_data_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   frame_state_type  st_ff, st_in, st_next;
   logic [15:0]      crc_ff, crc_in, crc_base, crc_fed;
   emit_type         emit;
   rsp_word_type     out_word;
   logic             out_ready, fire, req_take;

   mrf_byte_gen u_byte_gen (
      .item       (in_data_ff),
      .state_cur  (st_ff),
      .crc_cur    (crc_ff),
      .idx        (idx_ff),
      .emit       (emit),
      .state_next (st_next)
   );

   assign crc_base = emit.restart_crc ? CRC_INIT : crc_ff;

   mrf_crc_step u_crc_step (
      .crc_base  (crc_base),
      .data_byte (emit.tx_byte),
      .crc_next  (crc_fed)
   );

   assign out_word.tx_byte    = emit.tx_byte;
   assign out_word.frame_last = emit.last;
   assign out_word.error      = emit.err;

   mrf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (out_word),
      .rsp_stall (rsp_stall),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // The next word enters in the same cycle as the final byte of the current one leaves.
   assign fire      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !(fire && emit.done);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      idx_in      = idx_ff;
      st_in       = st_ff;
      crc_in      = crc_ff;
      if (fire) begin
         if (emit.done) begin
            in_valid_in = 1'b0;
            idx_in      = '0;
            st_in       = st_next;
         end else begin
            idx_in = idx_ff + {{(IDX_W-1){1'b0}}, 1'b1};
         end
         if (emit.clear_crc) begin
            crc_in = CRC_INIT;
         end else if (emit.feed_crc) begin
            crc_in = crc_fed;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         idx_ff      <= '0;
         st_ff       <= '0;
         crc_ff      <= CRC_INIT;
      end else begin
         in_valid_ff <= in_valid_in;
         idx_ff      <= idx_in;
         st_ff       <= st_in;
         crc_ff      <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   `MRF_ASSERT_NOW(a_idx_needs_word, clock, reset, idx_ff != '0, in_valid_ff, "byte index advanced with no word held")
   `MRF_ASSERT_NOW(a_open_frame_count, clock, reset, 1'b1, st_ff.awaiting == (st_ff.remaining != 8'd0), "open frame flag disagrees with payload count")
   `MRF_ASSERT_NEXT(a_crc_cleared, clock, reset, fire && emit.clear_crc, crc_ff == CRC_INIT, "CRC not restored after frame end")

endmodule

`default_nettype wire

### src/mrf_crc_step.sv
// One-byte update of the Modbus CRC-16 (reflected polynomial 0xA001).
// Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none

module mrf_crc_step (
   input  logic [15:0] crc_base,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   localparam logic [15:0] CRC_POLY = 16'hA001;

   logic [15:0] c;

   always_comb begin
      c = crc_base ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_next = c;
   end

endmodule

`default_nettype wire

### src/mrf_byte_gen.sv
// Decodes the held request word and selects the frame byte at the current index.
// Depends on mrf_pkg for the word types, request codes and function code tables.
`timescale 1ns / 1ps
`default_nettype none

module mrf_byte_gen (
   input  mrf_pkg::req_word_type      item,
   input  mrf_pkg::frame_state_type   state_cur,
   input  logic [15:0]                crc_cur,
   input  logic [mrf_pkg::IDX_W-1:0]  idx,
   output mrf_pkg::emit_type          emit,
   output mrf_pkg::frame_state_type   state_next
);
   import mrf_pkg::*;

   localparam logic [2:0] KIND_ERR_KEEP  = 3'd0;
   localparam logic [2:0] KIND_ERR_CLEAR = 3'd1;
   localparam logic [2:0] KIND_HDR_FULL  = 3'd2;
   localparam logic [2:0] KIND_HDR_MULTI = 3'd3;
   localparam logic [2:0] KIND_PAY_COIL  = 3'd4;
   localparam logic [2:0] KIND_PAY_REG   = 3'd5;

   logic [2:0]       kind;
   logic [16:0]      qty_sum;
   logic [7:0]       byte_cnt;
   logic             pay_last;
   logic             is_regs_hdr;
   logic [IDX_W-1:0] crc_idx;

   always_comb begin
      priority if (item.req_type == REQ_PAYLOAD) begin
         if (!state_cur.awaiting || state_cur.remaining == 8'd0) begin
            kind = KIND_ERR_KEEP;
         end else if (state_cur.is_registers) begin
            kind = KIND_PAY_REG;
         end else begin
            kind = KIND_PAY_COIL;
         end
      end else if (item.req_type > REQ_PAYLOAD) begin
         kind = KIND_ERR_KEEP;
      end else if (item.req_type != REQ_WRITE_COIL && item.req_type != REQ_WRITE_REG &&
                   (item.qty_or_value == 16'd0 ||
                    item.qty_or_value > qty_limit(item.req_type[2:0]))) begin
         kind = KIND_ERR_CLEAR;
      end else if (item.req_type < REQ_WRITE_COILS) begin
         kind = KIND_HDR_FULL;
      end else begin
         kind = KIND_HDR_MULTI;
      end
   end

   // Coil byte count is the quantity rounded up to whole bytes.
   assign qty_sum     = {1'b0, item.qty_or_value} + 17'd7;
   assign is_regs_hdr = (item.req_type == REQ_WRITE_REGS);
   assign byte_cnt    = is_regs_hdr ? {item.qty_or_value[6:0], 1'b0} : qty_sum[10:3];
   assign pay_last    = (state_cur.remaining == 8'd1);

   // Register words take two data bytes, coil bytes one; the CRC
   // follows only on the final payload word of the frame.
   assign crc_idx = (kind == KIND_PAY_REG) ? 3'd2 : 3'd1;

   always_comb begin
      emit       = '0;
      state_next = state_cur;
      unique case (kind)
         KIND_ERR_CLEAR: begin
            emit.last      = 1'b1;
            emit.err       = 1'b1;
            emit.clear_crc = 1'b1;
            emit.done      = 1'b1;
            state_next     = '0;
         end
         KIND_HDR_FULL, KIND_HDR_MULTI: begin
            // A header abandons any open frame, so its CRC starts over.
            emit.restart_crc = (idx == '0);
            emit.feed_crc    = 1'b1;
            unique case (idx)
               3'd0: emit.tx_byte = item.device_address;
               3'd1: emit.tx_byte = fn_code(item.req_type[2:0]);
               3'd2: emit.tx_byte = item.start_address[15:8];
               3'd3: emit.tx_byte = item.start_address[7:0];
               3'd4: emit.tx_byte = item.qty_or_value[15:8];
               3'd5: emit.tx_byte = item.qty_or_value[7:0];
               3'd6: begin
                  if (kind == KIND_HDR_FULL) begin
                     emit.tx_byte  = crc_cur[7:0];
                     emit.feed_crc = 1'b0;
                  end else begin
                     emit.tx_byte = byte_cnt;
                     emit.done    = 1'b1;
                  end
               end
               3'd7: begin
                  emit.tx_byte   = crc_cur[15:8];
                  emit.feed_crc  = 1'b0;
                  emit.last      = 1'b1;
                  emit.clear_crc = 1'b1;
                  emit.done      = 1'b1;
               end
            endcase
            if (kind == KIND_HDR_FULL) begin
               state_next = '0;
            end else begin
               state_next.awaiting     = 1'b1;
               state_next.is_registers = is_regs_hdr;
               state_next.remaining    = is_regs_hdr ? item.qty_or_value[7:0] : byte_cnt;
            end
         end
         KIND_PAY_COIL, KIND_PAY_REG: begin
            if (idx == 3'd0 && kind == KIND_PAY_REG) begin
               emit.tx_byte  = item.data_word[15:8];
               emit.feed_crc = 1'b1;
            end else if (idx < crc_idx) begin
               emit.tx_byte  = item.data_word[7:0];
               emit.feed_crc = 1'b1;
               emit.done     = !pay_last;
            end else if (idx == crc_idx) begin
               emit.tx_byte = crc_cur[7:0];
            end else begin
               emit.tx_byte   = crc_cur[15:8];
               emit.last      = 1'b1;
               emit.clear_crc = 1'b1;
               emit.done      = 1'b1;
            end
            state_next.remaining = state_cur.remaining - 8'd1;
            if (pay_last) begin
               state_next.awaiting     = 1'b0;
               state_next.is_registers = 1'b0;
            end
         end
         default: begin
            emit.last = 1'b1;
            emit.err  = 1'b1;
            emit.done = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/mrf_out_reg.sv
// Output register of the framer: holds one result word until the sink takes it.
// Depends on mrf_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module mrf_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  mrf_pkg::rsp_word_type load_data,
   input  logic                  rsp_stall,
   output logic                  ready,
   output logic                  rsp_valid,
   output mrf_pkg::rsp_word_type rsp_data
);
   import mrf_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type data_ff;

   assign ready     = !valid_ff || !rsp_stall;
   assign valid_in  = ready ? load : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire
